@@ rtl/u8d_pkg.sv @@
// shared types and constants for the utf-8 31-bit stream decoder
// no dependencies
package u8d_pkg;

  localparam int ByteW = 8;
  localparam int CpW   = 31;
  localparam int LenW  = 3;

  localparam logic [ByteW-1:0] ContMask  = 8'hc0;
  localparam logic [ByteW-1:0] ContTag   = 8'h80;
  localparam logic [ByteW-1:0] Lead2Base = 8'hc0;
  localparam logic [ByteW-1:0] Lead3Base = 8'he0;
  localparam logic [ByteW-1:0] Lead4Base = 8'hf0;
  localparam logic [ByteW-1:0] Lead5Base = 8'hf8;
  localparam logic [ByteW-1:0] Lead6Base = 8'hfc;
  localparam logic [ByteW-1:0] BadLead   = 8'hfe;
  localparam logic [ByteW-1:0] Bits2Mask = 8'h1f;
  localparam logic [ByteW-1:0] Bits3Mask = 8'h0f;
  localparam logic [ByteW-1:0] Bits4Mask = 8'h07;
  localparam logic [ByteW-1:0] Bits5Mask = 8'h03;
  localparam logic [ByteW-1:0] Bits6Mask = 8'h01;
  localparam logic [ByteW-1:0] PayMask   = 8'h3f;

  localparam logic [LenW-1:0] LenNone = 3'd0;
  localparam logic [LenW-1:0] Len1    = 3'd1;
  localparam logic [LenW-1:0] Len2    = 3'd2;
  localparam logic [LenW-1:0] Len3    = 3'd3;
  localparam logic [LenW-1:0] Len4    = 3'd4;
  localparam logic [LenW-1:0] Len5    = 3'd5;
  localparam logic [LenW-1:0] Len6    = 3'd6;

  typedef struct packed {
    logic [ByteW-1:0] byte_in;
    logic             message_end;
  } in_item_t;

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic [LenW-1:0] seq_length;
    logic            error;
  } result_t;

endpackage

@@ rtl/u8d_if.sv @@
// valid/ready channel interfaces for the byte input and the decoded result
// depends on u8d_pkg
interface u8d_byte_if
  import u8d_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_in;
  logic             message_end;

  modport source(output valid, output byte_in, output message_end, input ready);
  modport sink(input valid, input byte_in, input message_end, output ready);
endinterface

interface u8d_result_if
  import u8d_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CpW-1:0]  code_point;
  logic [LenW-1:0] seq_length;
  logic            error;

  modport source(output valid, output code_point, output seq_length, output error,
                 input ready);
  modport sink(input valid, input code_point, input seq_length, input error,
               output ready);
endinterface

@@ rtl/utf8_31bit_stream_decoder_unit.sv @@
// top level of the utf-8 31-bit stream decoder
// depends on u8d_pkg, u8d_if, u8d_in_stage, u8d_decode, u8d_out_stage
//
// in_bus carries one raw byte per beat with message_end set on the last
// byte of a message. out_bus carries decoded results: code_point and
// seq_length for a finished sequence, or error for the first bad or
// truncated sequence of a message; the rest of that message is dropped.
// bytes that only open or extend a sequence give no result beat.
// one byte is accepted every cycle while the receiver takes results; a byte is
// registered on entry, decoded from the input register, and its result beat is
// registered in the result register. the decode step between the two registers
// carries the open-sequence state byte to byte. when the receiver stalls the
// result register holds; the input register still takes one more byte, then
// in_bus.ready drops until space frees.
// reset (rst_n low, synchronous) empties both registers and clears the
// sequence state and the sticky error flag.
module utf8_31bit_stream_decoder_unit
  import u8d_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  u8d_byte_if.sink     in_bus,
  u8d_result_if.source out_bus
);

  logic     item_valid;
  in_item_t item;
  logic     space;
  logic     step;
  logic     emit;
  result_t  result;

  assign step = item_valid && space;

  u8d_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  u8d_decode u_dec (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item),
    .emit   (emit),
    .result (result)
  );

  u8d_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (step && emit),
    .result  (result),
    .space   (space),
    .out_bus (out_bus)
  );

endmodule

@@ rtl/u8d_in_stage.sv @@
// input register: captures one byte beat and holds it until the decoder takes it
// depends on u8d_pkg and u8d_byte_if
module u8d_in_stage
  import u8d_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  u8d_byte_if.sink      in_bus,
  input  logic          take,
  output logic          item_valid,
  output in_item_t      item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     load;

  assign in_bus.ready = !valid_r || take;
  assign load         = in_bus.valid && in_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.byte_in     <= in_bus.byte_in;
      item_r.message_end <= in_bus.message_end;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ rtl/u8d_decode.sv @@
// decoder state and single-step decode of one byte
// depends on u8d_pkg
module u8d_decode
  import u8d_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  in_item_t item,
  output logic     emit,
  output result_t  result
);

  logic [LenW-1:0] bytes_left_r, bytes_left_nxt;
  logic [CpW-1:0]  acc_r, acc_nxt;
  logic [LenW-1:0] cur_len_r, cur_len_nxt;
  logic            err_seen_r, err_seen_nxt;

  logic [ByteW-1:0] b;
  logic             last;
  logic [LenW-1:0]  lead_len;
  logic [ByteW-1:0] lead_bits;
  logic [CpW-1:0]   acc_shift;
  logic [LenW-1:0]  left_dec;

  assign b    = item.byte_in;
  assign last = item.message_end;

  // lead byte classification
  always_comb begin
    lead_len  = LenNone;
    lead_bits = '0;
    if (b < ContTag) begin
      lead_len  = Len1;
      lead_bits = b;
    end else if (b < Lead2Base) begin
      lead_len  = LenNone;
    end else if (b < Lead3Base) begin
      lead_len  = Len2;
      lead_bits = b & Bits2Mask;
    end else if (b < Lead4Base) begin
      lead_len  = Len3;
      lead_bits = b & Bits3Mask;
    end else if (b < Lead5Base) begin
      lead_len  = Len4;
      lead_bits = b & Bits4Mask;
    end else if (b < Lead6Base) begin
      lead_len  = Len5;
      lead_bits = b & Bits5Mask;
    end else if (b < BadLead) begin
      lead_len  = Len6;
      lead_bits = b & Bits6Mask;
    end
  end

  assign acc_shift = {acc_r[CpW-7:0], b[5:0]};
  assign left_dec  = bytes_left_r - Len1;

  always_comb begin
    emit           = 1'b0;
    result         = '0;
    bytes_left_nxt = bytes_left_r;
    acc_nxt        = acc_r;
    cur_len_nxt    = cur_len_r;
    err_seen_nxt   = err_seen_r;
    if (err_seen_r) begin
      // rest of message dropped
    end else if (bytes_left_r == LenNone) begin
      if (lead_len == LenNone) begin
        err_seen_nxt = 1'b1;
        emit         = 1'b1;
        result.error = 1'b1;
      end else if (lead_len == Len1) begin
        emit              = 1'b1;
        result.code_point = {{(CpW-ByteW){1'b0}}, lead_bits};
        result.seq_length = Len1;
      end else if (last) begin
        err_seen_nxt = 1'b1;
        emit         = 1'b1;
        result.error = 1'b1;
      end else begin
        cur_len_nxt    = lead_len;
        bytes_left_nxt = lead_len - Len1;
        acc_nxt        = {{(CpW-ByteW){1'b0}}, lead_bits};
      end
    end else begin
      if ((b & ContMask) != ContTag) begin
        err_seen_nxt = 1'b1;
        emit         = 1'b1;
        result.error = 1'b1;
      end else begin
        acc_nxt        = acc_shift;
        bytes_left_nxt = left_dec;
        if (left_dec == LenNone) begin
          emit              = 1'b1;
          result.code_point = acc_shift;
          result.seq_length = cur_len_r;
          acc_nxt           = '0;
          cur_len_nxt       = LenNone;
        end else if (last) begin
          err_seen_nxt = 1'b1;
          emit         = 1'b1;
          result.error = 1'b1;
        end
      end
    end
    if (last) begin
      bytes_left_nxt = LenNone;
      acc_nxt        = '0;
      cur_len_nxt    = LenNone;
      err_seen_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= LenNone;
      acc_r        <= '0;
      cur_len_r    <= LenNone;
      err_seen_r   <= 1'b0;
    end else if (step) begin
      bytes_left_r <= bytes_left_nxt;
      acc_r        <= acc_nxt;
      cur_len_r    <= cur_len_nxt;
      err_seen_r   <= err_seen_nxt;
    end
  end

endmodule

@@ rtl/u8d_out_stage.sv @@
// result register: holds one decoded result beat until the receiver takes it
// depends on u8d_pkg and u8d_result_if
module u8d_out_stage
  import u8d_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  result_t       result,
  output logic          space,
  u8d_result_if.source  out_bus
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign space = !valid_r || out_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_bus.valid      = valid_r;
  assign out_bus.code_point = res_r.code_point;
  assign out_bus.seq_length = res_r.seq_length;
  assign out_bus.error      = res_r.error;

endmodule
